@@ rtl/table_carrier_cycle_generator_assert.svh @@
// Assertion macros used by the checker file tccg_checker.sv.
`ifndef TABLE_CARRIER_CYCLE_GENERATOR_ASSERT_SVH
`define TABLE_CARRIER_CYCLE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tccg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tccg_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_IF1_MULT   = 2'd0;
    localparam logic [1:0] CFG_IF2_MULT   = 2'd1;
    localparam logic [1:0] CFG_RX_CONST   = 2'd2;
    localparam logic [1:0] CFG_USE_RX_CLK = 2'd3;

    // pi/2 in Q2.30, and the divisors (2k)(2k+1) of the sine series.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TERM_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic signed [47:0] sat_carr_cycles;
        logic signed [47:0] rx_clock;
        logic        [4:0]  coarse_phase;
        logic        [15:0] fine_phase;
    } tccg_in_t;

    typedef struct packed {
        logic signed [15:0] sample_i;
        logic signed [15:0] sample_q;
        logic               in_partial_cycle;
        logic               last;
        logic        [4:0]  start_index;
        logic        [4:0]  residue_coarse;
        logic        [15:0] residue_fine;
        logic signed [31:0] total_cycles;
    } tccg_out_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIFF,
        ST_SPLIT,
        ST_GEN
    } tccg_state_t;

endpackage

`default_nettype wire

@@ rtl/tccg_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/table_carrier_cycle_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Table carrier cycle generator.
// Input: item is taken at a rising edge with start high and busy low. The IF
// cycle count is sat_carr_cycles - (if1_mult + if2_mult) * clock, the clock
// being item.rx_clock if CFG_USE_RX_CLK is set, else the CFG_RX_CONST value.
// Output: one I/Q word per cycle on result, marked by strobe. First a full
// table cycle rotated to start at coarse_phase, then the partial cycle of
// "steps" words. The last word carries residue phases and total_cycles.
// Busy stays high from acceptance until the last word's RAM read is issued,
// so no new item is taken before then. Setup states: MUL_LO and MUL_HI, the
// two split multiplies of the 48-bit clock; SUM; DIFF, the subtract; and
// SPLIT, the fraction split. Then GEN issues one sine/cosine RAM read per
// word, TABLE_POINTS + steps words in all (steps in 0..TABLE_POINTS).
// Reset: config registers clear to 0, then the sample RAM is loaded from the
// constant table, one entry per cycle, with busy high.
// Config writes are taken at any time and should only come while idle.
// The receiver cannot stall: every strobe word is final.
module table_carrier_cycle_generator #(
    parameter int TABLE_POINTS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tccg_pkg::tccg_in_t  item,
    output logic                     strobe,
    output tccg_pkg::tccg_out_t      result,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [47:0]         cfg_data
);

    import tccg_pkg::*;

    localparam int IW = $clog2(TABLE_POINTS);        // table index
    localparam int SW = $clog2(TABLE_POINTS + 1);    // step count, 0..TABLE_POINTS
    localparam int CW = $clog2(2 * TABLE_POINTS);    // word counter
    localparam int SCW = 16 + SW;

    localparam logic signed [43:0] SAT_MAX = 44'sd2147483647;
    localparam logic signed [43:0] SAT_MIN = -44'sd2147483648;

    // ---------------------------------------------------------------
    // Constant tables, built at elaboration
    // ---------------------------------------------------------------

    // round(16384 * sin((pi/2) * r / TABLE_POINTS)), r in 0..TABLE_POINTS
    function automatic logic [15:0] quarter_sine(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        x = (HALF_PI_Q30 * 64'(r) + 64'(TABLE_POINTS / 2)) / TABLE_POINTS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / TERM_DIV[k-1];
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (sum + 32768) >>> 16;
        if (q > 16384)
            q = 16384;
        return 16'(q);
    endfunction

    // {cos, sin} for table entry idx
    function automatic logic [31:0] rom_entry(input int unsigned idx);
        int unsigned n;
        int unsigned quad;
        int unsigned r;
        logic [15:0] s;
        logic [15:0] c;
        logic [31:0] v;
        n = 4 * idx;
        quad = n / TABLE_POINTS;
        r = n % TABLE_POINTS;
        s = quarter_sine(r);
        c = quarter_sine(TABLE_POINTS - r);
        case (quad[1:0])
            2'd0:    v = {c, s};
            2'd1:    v = {16'(-s), c};
            2'd2:    v = {16'(-c), 16'(-s)};
            default: v = {s, 16'(-c)};
        endcase
        return v;
    endfunction

    function automatic logic [TABLE_POINTS*32-1:0] build_rom();
        logic [TABLE_POINTS*32-1:0] v;
        v = '0;
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            v[i*32 +: 32] = rom_entry(i);
        end
        return v;
    endfunction

    // coarse_phase modulo TABLE_POINTS for every 5-bit code
    function automatic logic [32*IW-1:0] build_mod();
        logic [32*IW-1:0] v;
        v = '0;
        for (int i = 0; i < 32; i++)
        begin
            v[i*IW +: IW] = IW'(i % TABLE_POINTS);
        end
        return v;
    endfunction

    localparam logic [TABLE_POINTS*32-1:0] ROM_INIT  = build_rom();
    localparam logic [32*IW-1:0]           MOD_TABLE = build_mod();

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tccg_state_t state_reg, state_next;

    logic [23:0]        if1_reg;
    logic [23:0]        if2_reg;
    logic signed [47:0] rxc_reg;
    logic               use_rx_reg;

    logic signed [47:0] sat_reg;
    logic signed [47:0] clk_reg;
    logic [24:0]        m_reg;
    logic [IW-1:0]      coarse_reg;
    logic [15:0]        fine_in_reg;

    logic [48:0]        plo_reg, plo_next;
    logic signed [49:0] phi_reg, phi_next;
    logic signed [57:0] prod_reg, prod_next;
    logic signed [58:0] ifv_reg, ifv_next;

    logic [IW-1:0]      end_reg, end_next;
    logic [15:0]        fine_res_reg, fine_res_next;
    logic signed [31:0] total_reg, total_next;
    logic [CW-1:0]      last_cnt_reg, last_cnt_next;

    logic [IW-1:0]      fill_cnt_reg;
    logic [CW-1:0]      gen_cnt_reg;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;

    logic               mv_reg;
    logic               mpart_reg;
    logic               mlast_reg;

    // control decoded from state
    logic accept;
    logic fill_we;
    logic issue;
    logic fill_done;
    logic gen_done;

    logic [31:0] ram_rdata;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if1_reg    <= '0;
            if2_reg    <= '0;
            rxc_reg    <= '0;
            use_rx_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IF1_MULT:   if1_reg    <= cfg_data[23:0];
                CFG_IF2_MULT:   if2_reg    <= cfg_data[23:0];
                CFG_RX_CONST:   rxc_reg    <= cfg_data;
                CFG_USE_RX_CLK: use_rx_reg <= cfg_data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    assign fill_done = (fill_cnt_reg == IW'(TABLE_POINTS - 1));
    assign gen_done  = (gen_cnt_reg == last_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:   if (fill_done) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SPLIT;
            ST_SPLIT:  state_next = ST_GEN;
            ST_GEN:    if (gen_done) state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        accept  = 1'b0;
        fill_we = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                fill_we = 1'b1;
            end
            ST_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            ST_GEN:
            begin
                issue = 1'b1;
            end
            ST_MUL_LO, ST_MUL_HI, ST_SUM, ST_DIFF, ST_SPLIT:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
            gen_cnt_reg  <= '0;
            mv_reg       <= 1'b0;
            mpart_reg    <= 1'b0;
            mlast_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fill_we)
            begin
                fill_cnt_reg <= fill_cnt_reg + IW'(1);
            end
            if (accept)
            begin
                gen_cnt_reg <= '0;
            end
            else if (issue)
            begin
                gen_cnt_reg <= gen_cnt_reg + CW'(1);
            end
            // word metadata rides alongside the RAM read
            mv_reg    <= issue;
            mpart_reg <= (gen_cnt_reg >= CW'(TABLE_POINTS));
            mlast_reg <= issue && gen_done;
        end
    end

    // ---------------------------------------------------------------
    // Setup datapath: clock * multiplier in two halves, then subtract
    // ---------------------------------------------------------------
    always_comb
    begin
        logic signed [23:0] clk_hi;
        logic signed [25:0] m_s;
        clk_hi    = clk_reg[47:24];
        m_s       = signed'({1'b0, m_reg});
        plo_next  = 49'(clk_reg[23:0]) * 49'(m_reg);
        phi_next  = 50'(clk_hi) * 50'(m_s);
        prod_next = (58'(phi_reg) <<< 8) + 58'(signed'({1'b0, plo_reg[48:16]}));
        ifv_next  = 59'(sat_reg) - 59'(prod_reg);
    end

    // Fraction split: steps and fine phase, end index wrap, saturated count
    always_comb
    begin
        logic [SCW-1:0]      scaled;
        logic [SW-1:0]       steps;
        logic [16:0]         fine_sum;
        logic [SW:0]         end_sum;
        logic                wrap;
        logic signed [43:0]  whole_inc;
        scaled   = SCW'(ifv_reg[15:0]) * SCW'(TABLE_POINTS);
        fine_sum = {1'b0, scaled[15:0]} + {1'b0, fine_in_reg};
        steps    = scaled[SCW-1:16] + SW'(fine_sum[16]);
        end_sum  = (SW+1)'(coarse_reg) + (SW+1)'(steps);
        wrap     = (end_sum >= (SW+1)'(TABLE_POINTS));
        end_next = wrap ? IW'(end_sum - (SW+1)'(TABLE_POINTS)) : IW'(end_sum);
        fine_res_next = fine_sum[15:0];
        whole_inc = 44'(signed'(ifv_reg[58:16])) + signed'(44'(wrap));
        if (whole_inc > SAT_MAX)
            total_next = SAT_MAX[31:0];
        else if (whole_inc < SAT_MIN)
            total_next = SAT_MIN[31:0];
        else
            total_next = whole_inc[31:0];
        last_cnt_next = CW'(TABLE_POINTS - 1) + CW'(steps);
    end

    // table walk; the full cycle ends back at the start index by itself
    assign rd_idx_next = (rd_idx_reg == IW'(TABLE_POINTS - 1)) ? '0 : rd_idx_reg + IW'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sat_reg     <= item.sat_carr_cycles;
            clk_reg     <= use_rx_reg ? item.rx_clock : rxc_reg;
            m_reg       <= 25'(if1_reg) + 25'(if2_reg);
            coarse_reg  <= MOD_TABLE[item.coarse_phase*IW +: IW];
            fine_in_reg <= item.fine_phase;
            rd_idx_reg  <= MOD_TABLE[item.coarse_phase*IW +: IW];
        end
        else if (issue)
        begin
            rd_idx_reg <= rd_idx_next;
        end
        if (state_reg == ST_MUL_LO)
        begin
            plo_reg <= plo_next;
        end
        if (state_reg == ST_MUL_HI)
        begin
            phi_reg <= phi_next;
        end
        if (state_reg == ST_SUM)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_DIFF)
        begin
            ifv_reg <= ifv_next;
        end
        if (state_reg == ST_SPLIT)
        begin
            end_reg      <= end_next;
            fine_res_reg <= fine_res_next;
            total_reg    <= total_next;
            last_cnt_reg <= last_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Sine/cosine RAM: {cos, sin} per entry, loaded after reset
    // ---------------------------------------------------------------
    tccg_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_cnt_reg),
        .wdata (ROM_INIT[fill_cnt_reg*32 +: 32]),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Result word
    // ---------------------------------------------------------------
    assign strobe = mv_reg;

    always_comb
    begin
        result.sample_i         = ram_rdata[31:16];
        result.sample_q         = ram_rdata[15:0];
        result.in_partial_cycle = mpart_reg;
        result.last             = mlast_reg;
        result.start_index      = 5'(coarse_reg);
        result.residue_coarse   = mlast_reg ? 5'(end_reg) : 5'd0;
        result.residue_fine     = mlast_reg ? fine_res_reg : 16'd0;
        result.total_cycles     = mlast_reg ? total_reg : 32'sd0;
    end

endmodule

`default_nettype wire

@@ rtl/tccg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "table_carrier_cycle_generator_assert.svh"

module tccg_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                strobe,
    input wire tccg_pkg::tccg_out_t result
);

    import tccg_pkg::*;

    logic accepted;
    logic mid_word;
    logic residue_zero;

    assign accepted     = start && !busy;
    assign mid_word     = strobe && !result.last;
    assign residue_zero = (result.residue_coarse == 5'd0) && (result.residue_fine == 16'd0)
                          && (result.total_cycles == 32'sd0);

    `TCCG_ASSERT_NEXT(a_accept_setup, accepted, busy && !strobe, "no word right after accept")
    `TCCG_ASSERT_NEXT(a_last_ends, strobe && result.last, !strobe, "word after last")
    `TCCG_ASSERT_NEXT(a_words_contiguous, mid_word, strobe, "gap inside an item's words")
    `TCCG_ASSERT_NOW(a_residue_last_only, mid_word, residue_zero, "residue on non-last word")

endmodule

bind table_carrier_cycle_generator tccg_checker u_tccg_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
